FILE: sv/patrol_obstacle_avoid_controller_core_assert.svh
// Assertion macros shared by the checker of the patrol controller core.
`ifndef PATROL_OBSTACLE_AVOID_CONTROLLER_CORE_ASSERT_SVH
`define PATROL_OBSTACLE_AVOID_CONTROLLER_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define POAC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("poac assertion failed");

// Clocked assertion that is also checked during reset.
`define POAC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("poac reset assertion failed");

`endif

FILE: sv/poac_pkg.sv
// Shared types, constants and codes of the patrol controller core.
package poac_pkg;

  localparam int ENC_WIDTH = 32;
  localparam int IR_WIDTH  = 16;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [1:0] MODE_DRIVE = 2'd0;
  localparam logic [1:0] MODE_AVOID = 2'd1;
  localparam logic [1:0] MODE_HALF  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_SPEED      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEG_LIMIT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TURN_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IR_OBSTACLE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IR_CLEAR        = 3'd5;

  typedef struct packed {
    logic [10:0] cruise_speed;
    logic [10:0] turn_speed;
    logic [31:0] leg_limit;
    logic [31:0] half_turn_limit;
    logic [15:0] obstacle_level;
    logic [15:0] clear_level;
  } cfg_t;

  // Raw tick as captured from the input channel.
  typedef struct packed {
    logic                 valid;
    logic [ENC_WIDTH-1:0] enc_left;
    logic [ENC_WIDTH-1:0] enc_right;
    logic [IR_WIDTH-1:0]  ir_front;
    logic [IR_WIDTH-1:0]  ir_front_left;
    logic [IR_WIDTH-1:0]  ir_front_right;
    logic [IR_WIDTH-1:0]  ir_side_left;
    logic [IR_WIDTH-1:0]  ir_side_right;
  } raw_t;

  // Tick after the delta stage.
  typedef struct packed {
    logic                 valid;
    logic                 prime;
    logic [ENC_WIDTH-1:0] dl;
    logic [ENC_WIDTH-1:0] dr;
    logic                 hit;
    logic                 clear;
    logic                 pick_left;
  } mid_t;

  // Tick ready for the mode update.
  typedef struct packed {
    logic                 valid;
    logic                 prime;
    logic                 fwd_pos;
    logic [ENC_WIDTH-1:0] fwd_mag;
    logic [ENC_WIDTH:0]   diff_mag;
    logic                 hit;
    logic                 clear;
    logic                 pick_left;
  } prep_t;

  typedef struct packed {
    logic [11:0] speed_left;
    logic [11:0] speed_right;
    logic [1:0]  mode_now;
  } res_t;

endpackage

FILE: sv/poac_prep.sv
// Encoder delta and proximity preprocessing, two registered stages.
module poac_prep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  poac_pkg::cfg_t cfg,
  input  poac_pkg::raw_t raw,
  output poac_pkg::prep_t prep
);
  import poac_pkg::*;

  logic [ENC_WIDTH-1:0] last_left_r, last_right_r;
  logic                 primed_r;
  mid_t                 mid_r, mid_nxt;
  prep_t                prep_r, prep_nxt;

  logic [IR_WIDTH-1:0]  front;
  logic [IR_WIDTH:0]    side_l, side_r;
  logic signed [ENC_WIDTH:0] fwd_s, diff_s, diff_abs;

  always_comb begin
    front = raw.ir_front;
    if (raw.ir_front_left > front) begin
      front = raw.ir_front_left;
    end
    if (raw.ir_front_right > front) begin
      front = raw.ir_front_right;
    end
    side_l = {1'b0, raw.ir_front_left} + {1'b0, raw.ir_side_left};
    side_r = {1'b0, raw.ir_front_right} + {1'b0, raw.ir_side_right};

    mid_nxt.valid     = raw.valid;
    mid_nxt.prime     = !primed_r;
    // Deltas wrap in the encoder width.
    mid_nxt.dl        = raw.enc_left - last_left_r;
    mid_nxt.dr        = raw.enc_right - last_right_r;
    mid_nxt.hit       = 16'(front) > cfg.obstacle_level;
    mid_nxt.clear     = 16'(front) < cfg.clear_level;
    mid_nxt.pick_left = side_l <= side_r;
  end

  always_comb begin
    fwd_s  = $signed({mid_r.dl[ENC_WIDTH-1], mid_r.dl}) +
             $signed({mid_r.dr[ENC_WIDTH-1], mid_r.dr});
    diff_s = $signed({mid_r.dr[ENC_WIDTH-1], mid_r.dr}) -
             $signed({mid_r.dl[ENC_WIDTH-1], mid_r.dl});
    diff_abs = diff_s[ENC_WIDTH] ? -diff_s : diff_s;

    prep_nxt.valid     = mid_r.valid;
    prep_nxt.prime     = mid_r.prime;
    prep_nxt.fwd_pos   = !fwd_s[ENC_WIDTH] && (fwd_s != '0);
    // A positive sum of two signed deltas always fits the encoder width.
    prep_nxt.fwd_mag   = fwd_s[ENC_WIDTH-1:0];
    prep_nxt.diff_mag  = diff_abs;
    prep_nxt.hit       = mid_r.hit;
    prep_nxt.clear     = mid_r.clear;
    prep_nxt.pick_left = mid_r.pick_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r     <= 1'b0;
      last_left_r  <= '0;
      last_right_r <= '0;
      mid_r.valid  <= 1'b0;
      prep_r.valid <= 1'b0;
    end else if (en) begin
      if (raw.valid) begin
        primed_r     <= 1'b1;
        last_left_r  <= raw.enc_left;
        last_right_r <= raw.enc_right;
      end
      mid_r  <= mid_nxt;
      prep_r <= prep_nxt;
    end
  end

  assign prep = prep_r;

endmodule

FILE: sv/poac_mode.sv
// Mode state machine with leg and half-turn accumulators.
module poac_mode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  poac_pkg::cfg_t  cfg,
  input  poac_pkg::prep_t prep,
  output poac_pkg::res_t  res
);
  import poac_pkg::*;

  logic [1:0]  mode_r, mode_nxt;
  logic [31:0] leg_sum_r, leg_sum_nxt;
  logic [31:0] turn_sum_r, turn_sum_nxt;
  logic        spin_left_r, spin_left_nxt;
  logic        spin;
  logic [33:0] leg_add, turn_add;
  logic [31:0] leg_sat, turn_sat;
  logic signed [11:0] t_pos;

  always_comb begin
    leg_add  = {2'b00, leg_sum_r} + 34'(prep.fwd_mag);
    turn_add = {2'b00, turn_sum_r} + 34'(prep.diff_mag);
    leg_sat  = (leg_add[33:32] != 2'b00) ? 32'hFFFF_FFFF : leg_add[31:0];
    turn_sat = (turn_add[33:32] != 2'b00) ? 32'hFFFF_FFFF : turn_add[31:0];
    t_pos    = $signed({1'b0, cfg.turn_speed});

    mode_nxt      = mode_r;
    leg_sum_nxt   = leg_sum_r;
    turn_sum_nxt  = turn_sum_r;
    spin_left_nxt = spin_left_r;
    spin          = 1'b0;
    res.speed_left  = '0;
    res.speed_right = '0;

    if (!prep.prime) begin
      unique case (mode_r)
        MODE_AVOID: begin
          spin = 1'b1;
          if (prep.clear) begin
            mode_nxt = MODE_DRIVE;
          end
        end
        MODE_HALF: begin
          spin         = 1'b1;
          turn_sum_nxt = turn_sat;
          if (turn_sat >= cfg.half_turn_limit) begin
            mode_nxt    = MODE_DRIVE;
            leg_sum_nxt = '0;
          end
        end
        default: begin
          // Drive, and the unused code that behaves as drive.
          mode_nxt = MODE_DRIVE;
          if (prep.hit) begin
            spin_left_nxt = prep.pick_left;
            mode_nxt      = MODE_AVOID;
            spin          = 1'b1;
          end else begin
            if (prep.fwd_pos) begin
              leg_sum_nxt = leg_sat;
            end
            if (leg_sum_nxt >= cfg.leg_limit) begin
              mode_nxt      = MODE_HALF;
              turn_sum_nxt  = '0;
              spin_left_nxt = 1'b1;
              spin          = 1'b1;
            end else begin
              res.speed_left  = {1'b0, cfg.cruise_speed};
              res.speed_right = {1'b0, cfg.cruise_speed};
            end
          end
        end
      endcase
    end

    if (spin) begin
      res.speed_left  = spin_left_nxt ? 12'(-t_pos) : 12'(t_pos);
      res.speed_right = spin_left_nxt ? 12'(t_pos) : 12'(-t_pos);
    end
    res.mode_now = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_DRIVE;
      leg_sum_r   <= '0;
      turn_sum_r  <= '0;
      spin_left_r <= 1'b1;
    end else if (en && prep.valid) begin
      mode_r      <= mode_nxt;
      leg_sum_r   <= leg_sum_nxt;
      turn_sum_r  <= turn_sum_nxt;
      spin_left_r <= spin_left_nxt;
    end
  end

endmodule

FILE: sv/patrol_obstacle_avoid_controller_core.sv
// Top level of the patrol controller core with obstacle avoidance.
//
//   channel  | direction | beat contents
//   ---------+-----------+------------------------------------------------
//   in_      | slave     | one control tick: encoder counts, IR readings
//   out_     | master    | wheel speed commands and mode after the tick
//   cfg_     | slave     | register index and write data
//
// One tick is accepted per cycle while the output is not stalled.
// The input register, two preprocessing stages and the output register form
// one pipeline that advances whenever the output register is free or drained.
// A stalled output holds the whole pipeline and deasserts in_tready.
// Reset is synchronous; config writes are always accepted.
module patrol_obstacle_avoid_controller_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // enc_left[31:0], enc_right[63:32], ir_front[79:64], ir_front_left[95:80],
  // ir_front_right[111:96], ir_side_left[127:112], ir_side_right[143:128]
  input  logic [poac_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // speed_left[11:0], speed_right[23:12], mode_now[25:24], zero fill above
  output logic [poac_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [poac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);
  import poac_pkg::*;

  logic  en;
  cfg_t  cfg_r;
  raw_t  in_r, in_nxt;
  prep_t prep;
  res_t  res;
  logic  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_nxt.valid          = in_tvalid;
    in_nxt.enc_left       = in_tdata[ENC_WIDTH-1:0];
    in_nxt.enc_right      = in_tdata[32 +: ENC_WIDTH];
    in_nxt.ir_front       = in_tdata[64 +: IR_WIDTH];
    in_nxt.ir_front_left  = in_tdata[80 +: IR_WIDTH];
    in_nxt.ir_front_right = in_tdata[96 +: IR_WIDTH];
    in_nxt.ir_side_left   = in_tdata[112 +: IR_WIDTH];
    in_nxt.ir_side_right  = in_tdata[128 +: IR_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cruise_speed    <= 11'd150;
      cfg_r.turn_speed      <= 11'd120;
      cfg_r.leg_limit       <= 32'd294800;
      cfg_r.half_turn_limit <= 32'd48808;
      cfg_r.obstacle_level  <= 16'd500;
      cfg_r.clear_level     <= 16'd300;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CRUISE_SPEED:    cfg_r.cruise_speed    <= cfg_data[10:0];
        CFG_TURN_SPEED:      cfg_r.turn_speed      <= cfg_data[10:0];
        CFG_LEG_LIMIT:       cfg_r.leg_limit       <= cfg_data;
        CFG_HALF_TURN_LIMIT: cfg_r.half_turn_limit <= cfg_data;
        CFG_IR_OBSTACLE:     cfg_r.obstacle_level  <= cfg_data[15:0];
        CFG_IR_CLEAR:        cfg_r.clear_level     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.valid  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      in_r        <= in_nxt;
      out_valid_r <= prep.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {6'd0, res.mode_now, res.speed_right, res.speed_left};
    end
  end

  poac_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg_r),
    .raw   (in_r),
    .prep  (prep)
  );

  poac_mode u_mode (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg_r),
    .prep  (prep),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: sv/poac_checker.sv
// Port-level checker for the patrol controller core, bound to the top level.
`include "patrol_obstacle_avoid_controller_core_assert.svh"

module poac_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [poac_pkg::OUT_DATA_W-1:0] out_tdata
);
  import poac_pkg::*;

  logic [1:0]  beat_mode;
  logic        spin_mode;
  logic [11:0] speed_sum;

  assign beat_mode = out_tdata[25:24];
  assign spin_mode = (beat_mode == MODE_AVOID) || (beat_mode == MODE_HALF);
  assign speed_sum = out_tdata[11:0] + out_tdata[23:12];

  // The output channel is empty in the cycle after reset.
  `POAC_ASSERT_RST(a_idle_after_reset, $past(!rst_n) |-> !out_tvalid)

  // A result that is not taken stays offered.
  `POAC_ASSERT(a_hold_valid, out_tvalid && !out_tready |=> out_tvalid)

  // A result that is not taken keeps its payload.
  `POAC_ASSERT(a_hold_data, out_tvalid && !out_tready |=> $stable(out_tdata))

  // Avoid and half-turn beats always spin in place: the two speeds cancel.
  `POAC_ASSERT(a_spin_balanced, out_tvalid && spin_mode |-> speed_sum == 12'd0)

endmodule

bind patrol_obstacle_avoid_controller_core poac_checker u_poac_checker (.*);

FILE: sim/patrol_obstacle_avoid_controller_core_checker.sv
// Checker for the patrol controller core: tracks controller state, predicts each beat.
`timescale 1ns / 1ps

module patrol_obstacle_avoid_controller_core_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [poac_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [poac_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [poac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              avoid_entries,
  output int                              legs_done,
  output int                              turns_done
);
  import poac_pkg::*;

  // Register copies.
  logic [10:0] cruise_spd;
  logic [10:0] turn_spd;
  logic [31:0] leg_lim;
  logic [31:0] turn_lim;
  logic [15:0] obs_lvl;
  logic [15:0] clr_lvl;

  // Controller state.
  logic [31:0] prev_left;
  logic [31:0] prev_right;
  logic        counts_latched;
  logic [1:0]  mode_cur;
  logic [31:0] leg_acc;
  logic [31:0] turn_total;
  logic        spin_ccw;

  res_t expected_cmds[$];
  int   results_checked;

  function automatic logic [31:0] add_sat(input logic [31:0] acc, input longint add);
    longint total;
    total = longint'(acc) + add;
    return (total > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s at result %0d: got 0x%0h, expected 0x%0h",
             field, results_checked, got, want);
    fail_count++;
  endtask

  task automatic apply_tick(input logic [IN_DATA_W-1:0] beat, output res_t cmd);
    logic [31:0] el, er, dl_w, dr_w;
    logic [15:0] f, fl, fr, sl, sr, front;
    logic [16:0] left_load, right_load;
    longint      dl, dr, fwd, diff;
    logic        spin;
    logic [11:0] tsp;
    el   = beat[31:0];
    er   = beat[63:32];
    f    = beat[79:64];
    fl   = beat[95:80];
    fr   = beat[111:96];
    sl   = beat[127:112];
    sr   = beat[143:128];
    cmd  = '0;
    spin = 1'b0;
    tsp  = {1'b0, turn_spd};
    // The first tick after reset only latches the encoder counts.
    if (!counts_latched) begin
      prev_left      = el;
      prev_right     = er;
      counts_latched = 1'b1;
      cmd.mode_now   = mode_cur;
      return;
    end
    dl_w = el - prev_left;
    dr_w = er - prev_right;
    dl   = $signed(dl_w);
    dr   = $signed(dr_w);
    prev_left  = el;
    prev_right = er;
    front = f;
    if (fl > front) front = fl;
    if (fr > front) front = fr;
    case (mode_cur)
      MODE_AVOID: begin
        spin = 1'b1;
        if (front < clr_lvl) mode_cur = MODE_DRIVE;
      end
      MODE_HALF: begin
        diff = dr - dl;
        if (diff < 0) diff = -diff;
        turn_total = add_sat(turn_total, diff);
        spin = 1'b1;
        if (turn_total >= turn_lim) begin
          mode_cur = MODE_DRIVE;
          leg_acc  = '0;
          turns_done++;
        end
      end
      default: begin
        mode_cur = MODE_DRIVE;
        if (front > obs_lvl) begin
          left_load  = fl + sl;
          right_load = fr + sr;
          spin_ccw   = (left_load <= right_load);
          mode_cur   = MODE_AVOID;
          spin       = 1'b1;
          avoid_entries++;
        end else begin
          fwd = dl + dr;
          if (fwd > 0) leg_acc = add_sat(leg_acc, fwd);
          if (leg_acc >= leg_lim) begin
            mode_cur   = MODE_HALF;
            turn_total = '0;
            spin_ccw   = 1'b1;
            spin       = 1'b1;
            legs_done++;
          end else begin
            cmd.speed_left  = {1'b0, cruise_spd};
            cmd.speed_right = {1'b0, cruise_spd};
          end
        end
      end
    endcase
    if (spin) begin
      cmd.speed_left  = spin_ccw ? (12'd0 - tsp) : tsp;
      cmd.speed_right = spin_ccw ? tsp : (12'd0 - tsp);
    end
    cmd.mode_now = mode_cur;
  endtask

  always @(posedge clk) begin
    res_t cmd;
    res_t want;
    if (!rst_n) begin
      cruise_spd     = 11'd150;
      turn_spd       = 11'd120;
      leg_lim        = 32'd294800;
      turn_lim       = 32'd48808;
      obs_lvl        = 16'd500;
      clr_lvl        = 16'd300;
      prev_left      = '0;
      prev_right     = '0;
      counts_latched = 1'b0;
      mode_cur       = MODE_DRIVE;
      leg_acc        = '0;
      turn_total     = '0;
      spin_ccw       = 1'b1;
      expected_cmds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CRUISE_SPEED:    cruise_spd = cfg_data[10:0];
          CFG_TURN_SPEED:      turn_spd   = cfg_data[10:0];
          CFG_LEG_LIMIT:       leg_lim    = cfg_data;
          CFG_HALF_TURN_LIMIT: turn_lim   = cfg_data;
          CFG_IR_OBSTACLE:     obs_lvl    = cfg_data[15:0];
          CFG_IR_CLEAR:        clr_lvl    = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        apply_tick(in_tdata, cmd);
        expected_cmds.push_back(cmd);
      end
      if (out_tvalid && out_tready) begin
        if (expected_cmds.size() == 0) begin
          flag_mismatch("unexpected beat", out_tdata, '0);
        end else begin
          want = expected_cmds.pop_front();
          if (out_tdata[11:0] !== want.speed_left)
            flag_mismatch("speed_left", out_tdata[11:0], want.speed_left);
          if (out_tdata[23:12] !== want.speed_right)
            flag_mismatch("speed_right", out_tdata[23:12], want.speed_right);
          if (out_tdata[25:24] !== want.mode_now)
            flag_mismatch("mode_now", out_tdata[25:24], want.mode_now);
          if (out_tdata[31:26] !== 6'd0)
            flag_mismatch("zero fill", out_tdata[31:26], '0);
        end
        results_checked++;
      end
    end
    pending = expected_cmds.size();
  end

endmodule

FILE: sim/patrol_obstacle_avoid_controller_core_tb.sv
// Testbench top for the patrol controller core: reset, configuration, tick stimulus, verdict.
`timescale 1ns / 1ps

module patrol_obstacle_avoid_controller_core_tb;
  import poac_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_TAIL     = 8;
  localparam int RANDOM_TICKS   = 100;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [31:0]           cfg_data;

  int fail_count;
  int pending;
  int avoid_entries;
  int legs_done;
  int turns_done;

  int          quiet_cycles = 0;
  int unsigned in_idle_pct  = 0;
  int unsigned out_stall_pct = 0;
  logic        hold_req     = 1'b0;
  int          hold_count;
  int          ticks_sent   = 0;
  int          settings_used = 0;
  logic [31:0] pos_l = '0;
  logic [31:0] pos_r = '0;
  logic [15:0] obs_thr = 16'd500;
  logic [15:0] clr_thr = 16'd300;

  patrol_obstacle_avoid_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  patrol_obstacle_avoid_controller_core_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .avoid_entries (avoid_entries),
    .legs_done     (legs_done),
    .turns_done    (turns_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("patrol_obstacle_avoid_controller_core verification failed");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_tick(input logic [31:0] el, input logic [31:0] er,
                           input logic [15:0] f, input logic [15:0] fl,
                           input logic [15:0] fr, input logic [15:0] sl,
                           input logic [15:0] sr);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {sr, sl, fr, fl, f, er, el};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    pos_l = el;
    pos_r = er;
    ticks_sent++;
  endtask

  task automatic send_delta(input logic [31:0] dl, input logic [31:0] dr,
                            input logic [15:0] f, input logic [15:0] fl,
                            input logic [15:0] fr, input logic [15:0] sl,
                            input logic [15:0] sr);
    send_tick(pos_l + dl, pos_r + dr, f, fl, fr, sl, sr);
  endtask

  task automatic wait_for_results();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [10:0] cruise, input logic [10:0] turn,
                               input logic [31:0] leg, input logic [31:0] half,
                               input logic [15:0] obs, input logic [15:0] clr);
    wait_for_results();
    write_reg(CFG_CRUISE_SPEED, {21'd0, cruise});
    write_reg(CFG_TURN_SPEED, {21'd0, turn});
    write_reg(CFG_LEG_LIMIT, leg);
    write_reg(CFG_HALF_TURN_LIMIT, half);
    write_reg(CFG_IR_OBSTACLE, {16'd0, obs});
    write_reg(CFG_IR_CLEAR, {16'd0, clr});
    cfg_valid = 1'b0;
    obs_thr = obs;
    clr_thr = clr;
    settings_used++;
  endtask

  // Reading near the current thresholds: clear, in the hysteresis band, blocked, or any value.
  function automatic logic [15:0] ir_level(input int unsigned cat);
    if (cat < 55) return (clr_thr == 0) ? 16'd0 : 16'($urandom_range(clr_thr - 1, 0));
    if (cat < 70) return 16'($urandom_range(obs_thr, clr_thr));
    if (cat < 90) return (obs_thr == 16'hFFFF) ? 16'hFFFF :
                         16'($urandom_range(16'hFFFF, obs_thr + 1));
    return 16'($urandom);
  endfunction

  task automatic random_tick();
    int unsigned mv;
    logic [31:0] dl, dr;
    logic [15:0] peak, f, fl, fr;
    mv   = $urandom_range(99);
    peak = ir_level($urandom_range(99));
    f    = 16'($urandom_range(peak));
    fl   = 16'($urandom_range(peak));
    fr   = 16'($urandom_range(peak));
    case ($urandom_range(2))
      0: f  = peak;
      1: fl = peak;
      default: fr = peak;
    endcase
    if (mv < 70) begin
      dl = $urandom_range(1500);
      dr = $urandom_range(1500);
    end else if (mv < 85) begin
      dl = 32'd0 - $urandom_range(1500);
      dr = $urandom_range(1500);
      if ($urandom_range(1)) {dl, dr} = {dr, dl};
    end else if (mv < 93) begin
      dl = 32'd0 - $urandom_range(200);
      dr = 32'd0 - $urandom_range(200);
    end else begin
      dl = $urandom;
      dr = $urandom;
    end
    send_delta(dl, dr, f, fl, fr, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    logic [15:0] obs;
    logic [15:0] clr;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings. The first tick only latches counts even with everything blocked.
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'd10, 32'd10, 16'd501, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'd0, 32'd0, 16'd300, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'd0, 32'd0, 16'd299, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'd5, 32'd5, 16'd0, 16'd600, 16'd0, 16'd10, 16'd0);
    send_delta(32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_delta(32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'd0, 32'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_delta(32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'd0 - 32'd100, 32'd0 - 32'd50, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);

    // Largest limits: both accumulators reach their top value, the leg sum by saturation.
    load_settings(11'd2047, 11'd2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd500, 16'd300);
    send_delta(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'd1000, 32'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);

    // Zero limits are met at once; the obstacle level cannot be exceeded.
    load_settings(11'd0, 11'd0, 32'd0, 32'd0, 16'hFFFF, 16'd0);
    repeat (4) send_delta(32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // Any nonzero reading blocks, and only a reading below the top level clears.
    load_settings(11'd1, 11'd1, 32'd5000, 32'd1, 16'd0, 16'hFFFF);
    send_delta(32'd0, 32'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'd0, 32'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'd0, 32'd0, 16'hFFFE, 16'd0, 16'd0, 16'd0, 16'd0);
    send_delta(32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_tick($urandom, $urandom, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);

    for (int ph = 0; ph < 4; ph++) begin
      obs = 16'($urandom_range(3000, 200));
      clr = 16'($urandom_range(obs, 0));
      load_settings(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                    $urandom_range(20000, 1), $urandom_range(5000, 1), obs, clr);
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 88; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 88; end
        default: begin in_idle_pct = 28; out_stall_pct = 28; end
      endcase
      for (int n = 0; n < RANDOM_TICKS; n++) begin
        // Long output hold-off while ticks keep coming, so the pipeline backs up.
        if (ph == 0 && n == 30) hold_req = 1'b1;
        if (ph == 1 && n == 50) wait_for_results();
        random_tick();
      end
    end

    wait_for_results();
    repeat (DRAIN_TAIL) @(negedge clk);
    $display("Run covered %0d ticks under %0d register settings and four handshake mixes.",
             ticks_sent, settings_used + 1);
    $display("Predicted %0d avoid entries, %0d finished legs and %0d finished half-turns.",
             avoid_entries, legs_done, turns_done);
    if (fail_count == 0) begin
      $display("patrol_obstacle_avoid_controller_core verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("patrol_obstacle_avoid_controller_core verification failed");
    end
    $finish;
  end

endmodule

FILE: patrol_obstacle_avoid_controller_core.f
+incdir+sv
sv/poac_pkg.sv
sv/poac_prep.sv
sv/poac_mode.sv
sv/patrol_obstacle_avoid_controller_core.sv
sv/poac_checker.sv
sim/patrol_obstacle_avoid_controller_core_checker.sv
sim/patrol_obstacle_avoid_controller_core_tb.sv
